/* rtl/sequential_list_engine_assert.svh */
// assertion macros used by the list engine rtl
`ifndef SEQUENTIAL_LIST_ENGINE_ASSERT_SVH
`define SEQUENTIAL_LIST_ENGINE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SLE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("list engine assertion failed");

// next-cycle implication, checked out of reset
`define SLE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("list engine assertion failed");

`endif

/* rtl/sle_pkg.sv */
package sle_pkg;

    // default sizes
    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed field widths
    localparam int FUNC_W   = 3;
    localparam int FIELD_W  = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    // match bits examined per scan cycle
    localparam int SCAN_GROUP = 8;

    localparam logic [FIELD_W-1:0] NOT_FOUND = {FIELD_W{1'b1}};

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_BACK  = 3'd0,
        FN_PUSH_FRONT = 3'd1,
        FN_POP_BACK   = 3'd2,
        FN_POP_FRONT  = 3'd3,
        FN_INSERT     = 3'd4,
        FN_ERASE      = 3'd5,
        FN_FIND       = 3'd6
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN,
        CELL_MATCH
    } cell_op_t;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    typedef struct packed {
        logic               done;
        logic               hit;
        logic [FIELD_W-1:0] index;
    } scan_res_t;

endpackage

/* rtl/sle_req_if.sv */
interface sle_req_if import sle_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [FUNC_W-1:0]          func;
    logic [FIELD_W-1:0]         position;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output func, output position, output value, input ready);
    modport sink   (input valid, input func, input position, input value, output ready);
endinterface

/* rtl/sle_rsp_if.sv */
interface sle_rsp_if import sle_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic signed [FIELD_W-1:0]  found_index;
    logic [FIELD_W-1:0]         count;

    modport source (output valid, output status, output found_index, output count, input ready);
    modport sink   (input valid, input status, input found_index, input count, output ready);
endinterface

/* rtl/sequential_list_engine.sv */
// push, pop, insert and erase: result registered in the cycle after the request is accepted
// find: cells register their compares, then the scanner checks 8 cells a cycle
// a new request is taken when idle and the result register is empty or being read in that cycle
// so back-to-back non-find requests run at one per cycle while the response side is ready
// reset clears the element count, the scan state and the pending result; cell contents stay
`include "sequential_list_engine_assert.svh"

module sequential_list_engine import sle_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    sle_req_if.sink   req,
    sle_rsp_if.source rsp
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMPW  = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;

    state_t              state_reg;
    state_t              state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    status_t             status_reg;
    status_t             status_next;
    logic [FIELD_W-1:0]  found_reg;
    logic [FIELD_W-1:0]  found_next;
    logic [FIELD_W-1:0]  rcount_reg;
    logic [FIELD_W-1:0]  rcount_next;

    logic                  in_ready;
    logic                  req_acc;
    logic                  full;
    logic                  empty;
    logic [CMPW-1:0]       pos_ext;
    logic [CMPW-1:0]       cnt_ext;
    logic [DATA_WIDTH-1:0] data_in;
    status_t               op_status;
    cell_op_t              cell_op;
    logic [AW-1:0]         cell_at;
    logic                  scan_start;
    scan_res_t             scan_res;

    logic [DATA_WIDTH-1:0] elem_w [DEPTH];
    logic [DEPTH-1:0]      match_w;

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign req_acc  = req.valid && in_ready;
    assign req.ready = in_ready;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pos_ext = CMPW'(req.position);
    assign cnt_ext = CMPW'(count_reg);
    assign data_in = DATA_WIDTH'(unsigned'(req.value));

    // request decode, cell command and result loading
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        status_next    = status_reg;
        found_next     = found_reg;
        rcount_next    = rcount_reg;
        op_status      = ST_OK;
        cell_op        = CELL_HOLD;
        cell_at        = '0;
        scan_start     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    case (func_t'(req.func))
                        FN_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                op_status = ST_FULL;
                            end
                            else
                            begin
                                cell_op    = CELL_SHIFT_UP;
                                cell_at    = AW'(count_reg);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        FN_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                op_status = ST_FULL;
                            end
                            else
                            begin
                                cell_op    = CELL_SHIFT_UP;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        FN_INSERT:
                        begin
                            if (full)
                            begin
                                op_status = ST_FULL;
                            end
                            else if (pos_ext > cnt_ext)
                            begin
                                op_status = ST_RANGE;
                            end
                            else
                            begin
                                cell_op    = CELL_SHIFT_UP;
                                cell_at    = AW'(req.position);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        FN_POP_BACK:
                        begin
                            if (empty)
                            begin
                                op_status = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        FN_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                op_status = ST_EMPTY;
                            end
                            else
                            begin
                                cell_op    = CELL_SHIFT_DOWN;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        FN_ERASE:
                        begin
                            if (empty)
                            begin
                                op_status = ST_EMPTY;
                            end
                            else if (pos_ext >= cnt_ext)
                            begin
                                op_status = ST_RANGE;
                            end
                            else
                            begin
                                cell_op    = CELL_SHIFT_DOWN;
                                cell_at    = AW'(req.position);
                                count_next = count_reg - 1'b1;
                            end
                        end
                        FN_FIND:
                        begin
                            cell_op    = CELL_MATCH;
                            scan_start = 1'b1;
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            op_status = ST_OK;
                        end
                    endcase
                    if (state_next == S_IDLE)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = op_status;
                        found_next     = NOT_FOUND;
                        rcount_next    = FIELD_W'(count_next);
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_res.done)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    found_next     = scan_res.hit ? scan_res.index : NOT_FOUND;
                    rcount_next    = FIELD_W'(count_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        found_reg  <= found_next;
        rcount_reg <= rcount_next;
    end

    // row of element cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_w;
        logic [DATA_WIDTH-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = elem_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = elem_w[i+1];
        end

        sle_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .AW         (AW),
            .INDEX      (i)
        ) u_cell (
            .clk   (clk),
            .op    (cell_op),
            .at    (cell_at),
            .data  (data_in),
            .left  (left_w),
            .right (right_w),
            .elem  (elem_w[i]),
            .match (match_w[i])
        );
    end

    // first-match search over the registered match bits
    sle_scan #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scan_start),
        .run   (state_reg == S_SCAN),
        .match (match_w),
        .count (count_reg),
        .res   (scan_res)
    );

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.found_index = $signed(found_reg);
    assign rsp.count       = rcount_reg;

    // checks
    `SLE_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH))
    `SLE_ASSERT_NEXT(a_find_scans, req_acc && (req.func == FN_FIND), state_reg == S_SCAN)
    `SLE_ASSERT_NEXT(a_count_idle, !req_acc, $stable(count_reg))
    `SLE_ASSERT_NEXT(a_refused_keeps, req_acc && (op_status != ST_OK), $stable(count_reg))

endmodule

/* rtl/sle_cell.sv */
module sle_cell import sle_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int AW         = 6,
    parameter int INDEX      = 0
)
(
    input  logic                  clk,
    input  cell_op_t              op,
    input  logic [AW-1:0]         at,
    input  logic [DATA_WIDTH-1:0] data,
    input  logic [DATA_WIDTH-1:0] left,
    input  logic [DATA_WIDTH-1:0] right,
    output logic [DATA_WIDTH-1:0] elem,
    output logic                  match
);

    localparam logic [AW-1:0] MY_INDEX = AW'(INDEX);

    logic [DATA_WIDTH-1:0] elem_reg;
    logic                  match_reg;

    // element storage: load, take a neighbour, or compare against the key
    always_ff @(posedge clk)
    begin
        case (op)
            CELL_SHIFT_UP:
            begin
                if (MY_INDEX == at)
                begin
                    elem_reg <= data;
                end
                else if (MY_INDEX > at)
                begin
                    elem_reg <= left;
                end
            end
            CELL_SHIFT_DOWN:
            begin
                if (MY_INDEX >= at)
                begin
                    elem_reg <= right;
                end
            end
            CELL_MATCH:
            begin
                match_reg <= (elem_reg == data);
            end
            default:
            begin
                elem_reg <= elem_reg;
            end
        endcase
    end

    assign elem  = elem_reg;
    assign match = match_reg;

endmodule

/* rtl/sle_scan.sv */
module sle_scan import sle_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int CNT_W = 7
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             run,
    input  logic [DEPTH-1:0] match,
    input  logic [CNT_W-1:0] count,
    output scan_res_t        res
);

    localparam int NG   = (DEPTH + SCAN_GROUP - 1) / SCAN_GROUP;
    localparam int GW   = (NG > 1) ? $clog2(NG) : 1;
    localparam int GL   = $clog2(SCAN_GROUP);
    localparam int PAD  = NG * SCAN_GROUP;
    localparam int IW   = $clog2(PAD);
    localparam int CMPW = (IW > CNT_W) ? IW : CNT_W;

    logic [GW-1:0]         grp_reg;
    logic [GW-1:0]         grp_next;
    logic [PAD-1:0]        padded;
    logic [IW-1:0]         base;
    logic [SCAN_GROUP-1:0] bits;
    logic [SCAN_GROUP-1:0] live;
    logic [GL-1:0]         sel;
    logic                  hit;
    logic                  last;

    assign padded = PAD'(match);

    // one group of match bits per cycle, masked to the occupied cells
    always_comb
    begin
        base = IW'(grp_reg) << GL;
        bits = padded[base +: SCAN_GROUP];
        sel  = '0;
        for (int k = 0; k < SCAN_GROUP; k++)
        begin
            live[k] = bits[k] && (CMPW'(base + IW'(k)) < CMPW'(count));
        end
        for (int k = SCAN_GROUP - 1; k >= 0; k--)
        begin
            if (live[k])
            begin
                sel = GL'(k);
            end
        end
        hit  = |live;
        last = (grp_reg == GW'(NG - 1));
    end

    // group pointer, held on the group that ends the scan
    always_comb
    begin
        grp_next = grp_reg;
        if (start)
        begin
            grp_next = '0;
        end
        else if (run && !(hit || last))
        begin
            grp_next = grp_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_reg <= '0;
        end
        else
        begin
            grp_reg <= grp_next;
        end
    end

    assign res.done  = run && (hit || last);
    assign res.hit   = run && hit;
    assign res.index = FIELD_W'(base + IW'(sel));

endmodule

/* sim/sequential_list_engine_test.sv */
module sequential_list_engine_test;
    import sle_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH = 64;
    localparam int LIST_WIDTH = 32;

    // operation code left unused by the block
    localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

    typedef struct packed {
        status_t                    status;
        logic signed [FIELD_W-1:0]  found_index;
        logic [FIELD_W-1:0]         count;
    } list_outcome_t;

    // shadow list and the outcomes still owed by the block
    class list_scoreboard;
        logic [LIST_WIDTH-1:0] held [LIST_DEPTH];
        int unsigned           held_count;
        list_outcome_t         awaited [$];
        int unsigned           mismatches;
        int unsigned           checked;
        int unsigned           refused_full;
        int unsigned           refused_empty;
        int unsigned           refused_range;
        int unsigned           finds_hit;
        int unsigned           peak_count;

        function new();
            held_count    = 0;
            mismatches    = 0;
            checked       = 0;
            refused_full  = 0;
            refused_empty = 0;
            refused_range = 0;
            finds_hit     = 0;
            peak_count    = 0;
        endfunction

        // apply one accepted request to the shadow list and queue its outcome
        function void note_request(logic [FUNC_W-1:0] code, logic [FIELD_W-1:0] pos,
                                   logic [LIST_WIDTH-1:0] val);
            list_outcome_t outcome;
            int            at;
            int            i;
            outcome.status      = ST_OK;
            outcome.found_index = $signed(NOT_FOUND);
            case (code)
                FN_PUSH_BACK, FN_PUSH_FRONT, FN_INSERT:
                begin
                    if (held_count >= LIST_DEPTH)
                    begin
                        outcome.status = ST_FULL;
                    end
                    else if (code == FN_INSERT && pos > held_count)
                    begin
                        outcome.status = ST_RANGE;
                    end
                    else
                    begin
                        if (code == FN_PUSH_BACK)
                            at = held_count;
                        else if (code == FN_PUSH_FRONT)
                            at = 0;
                        else
                            at = int'(pos);
                        // open a gap, moving from the end of the list
                        for (i = held_count; i > at; i--)
                            held[i] = held[i-1];
                        held[at] = val;
                        held_count++;
                    end
                end
                FN_POP_BACK, FN_POP_FRONT, FN_ERASE:
                begin
                    if (held_count == 0)
                    begin
                        outcome.status = ST_EMPTY;
                    end
                    else if (code == FN_ERASE && pos >= held_count)
                    begin
                        outcome.status = ST_RANGE;
                    end
                    else
                    begin
                        if (code == FN_POP_BACK)
                            at = held_count - 1;
                        else if (code == FN_POP_FRONT)
                            at = 0;
                        else
                            at = int'(pos);
                        // close the gap
                        for (i = at; i + 1 < held_count; i++)
                            held[i] = held[i+1];
                        held_count--;
                    end
                end
                FN_FIND:
                begin
                    for (i = 0; i < held_count; i++)
                    begin
                        if (held[i] == val)
                        begin
                            outcome.found_index = FIELD_W'(i);
                            break;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            outcome.count = FIELD_W'(held_count);
            if (outcome.status == ST_FULL)
                refused_full++;
            if (outcome.status == ST_EMPTY)
                refused_empty++;
            if (outcome.status == ST_RANGE)
                refused_range++;
            if (outcome.found_index != $signed(NOT_FOUND))
                finds_hit++;
            if (held_count > peak_count)
                peak_count = held_count;
            awaited.push_back(outcome);
        endfunction

        // compare one accepted response with the oldest outcome owed
        function void check_response(logic [STATUS_W-1:0] status,
                                     logic signed [FIELD_W-1:0] found_index,
                                     logic [FIELD_W-1:0] count);
            list_outcome_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                $display("%0t: response with no request outstanding: status %0d index %0d count %0d",
                         $time, status, found_index, count);
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (status !== want.status)
            begin
                mismatches++;
                $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            end
            if (found_index !== want.found_index)
            begin
                mismatches++;
                $display("%0t: found_index expected %0d actual %0d",
                         $time, want.found_index, found_index);
            end
            if (count !== want.count)
            begin
                mismatches++;
                $display("%0t: count expected %0d actual %0d", $time, want.count, count);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   no_idle;
    int   stall_left;

    sle_req_if req_ch ();
    sle_rsp_if rsp_ch ();

    list_scoreboard board;

    sequential_list_engine #(
        .DEPTH      (LIST_DEPTH),
        .DATA_WIDTH (LIST_WIDTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // overall time limit
    initial
    begin
        #2000000;
        $display("timeout with %0d responses outstanding", board.awaited.size());
        $display("FAILED: results differ");
        $finish;
    end

    // idle length: mostly none or short, now and then long
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // response side back-pressure
    initial
    begin
        rsp_ch.ready = 1'b0;
        stall_left   = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) < 25)
                    stall_left = idle_length();
            end
        end
    end

    // response monitor
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                board.check_response(rsp_ch.status, rsp_ch.found_index, rsp_ch.count);
        end
    end

    // drive one request and hold it until accepted
    task automatic send_request(input logic [FUNC_W-1:0] code, input logic [FIELD_W-1:0] pos,
                                input logic [LIST_WIDTH-1:0] val);
        int gap;
        gap = idle_length();
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.func     <= code;
        req_ch.position <= pos;
        req_ch.value    <= val;
        forever
        begin
            @(posedge clk);
            if (req_ch.ready)
                break;
        end
        board.note_request(code, pos, val);
    endtask

    // element value: a held one, a small one that repeats, an extreme or anything
    function automatic logic [LIST_WIDTH-1:0] pick_value(input int copy_pct);
        int r;
        if (board.held_count > 0 && $urandom_range(0, 99) < copy_pct)
            return board.held[$urandom_range(0, board.held_count - 1)];
        r = $urandom_range(0, 99);
        if (r < 40)
            return $urandom;
        if (r < 85)
            return $urandom_range(0, 6) - 3;
        case ($urandom_range(0, 2))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // one random request, weighted towards growing or shrinking the list
    task automatic random_request(input int grow_pct);
        logic [FUNC_W-1:0]     code;
        logic [FIELD_W-1:0]    pos;
        logic [LIST_WIDTH-1:0] val;
        int                    r;
        int                    n;
        n = board.held_count;
        r = $urandom_range(0, 99);
        if (r < 3)
            code = FN_UNUSED;
        else if (r < 18)
            code = FN_FIND;
        else if ($urandom_range(0, 99) < grow_pct)
        begin
            case ($urandom_range(0, 2))
                0:       code = FN_PUSH_BACK;
                1:       code = FN_PUSH_FRONT;
                default: code = FN_INSERT;
            endcase
        end
        else
        begin
            case ($urandom_range(0, 2))
                0:       code = FN_POP_BACK;
                1:       code = FN_POP_FRONT;
                default: code = FN_ERASE;
            endcase
        end
        // position mostly inside the list, its end included
        r = $urandom_range(0, 9);
        if (r < 8)
            pos = FIELD_W'($urandom_range(0, n));
        else if (r == 8)
            pos = FIELD_W'(n + $urandom_range(1, 3));
        else
            pos = FIELD_W'($urandom_range(0, 127));
        val = pick_value(code == FN_FIND ? 60 : 15);
        send_request(code, pos, val);
    endtask

    // stimulus and verdict
    initial
    begin
        int k;
        board = new();
        no_idle         = 1'b0;
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.func     = '0;
        req_ch.position = '0;
        req_ch.value    = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // refusals on an empty list, find on empty, unused code
        send_request(FN_POP_BACK, 7'd0, 32'd0);
        send_request(FN_POP_FRONT, 7'd0, 32'd0);
        send_request(FN_ERASE, 7'd0, 32'd0);
        send_request(FN_FIND, 7'd0, 32'd0);
        send_request(FN_UNUSED, 7'd127, 32'hFFFF_FFFF);
        send_request(FN_INSERT, 7'd1, 32'd9);
        // build a short list with extreme values and a duplicate
        send_request(FN_INSERT, 7'd0, 32'h7FFF_FFFF);
        send_request(FN_PUSH_BACK, 7'd0, 32'h8000_0000);
        send_request(FN_PUSH_FRONT, 7'd127, 32'd0);
        send_request(FN_INSERT, 7'd3, 32'hFFFF_FFFF);
        send_request(FN_INSERT, 7'd2, 32'd5);
        send_request(FN_FIND, 7'd0, 32'hFFFF_FFFF);
        send_request(FN_PUSH_BACK, 7'd0, 32'd5);
        send_request(FN_FIND, 7'd0, 32'd5);
        send_request(FN_FIND, 7'd0, 32'd12345);
        // bad positions
        send_request(FN_ERASE, 7'd6, 32'd0);
        send_request(FN_ERASE, 7'd127, 32'd0);
        send_request(FN_INSERT, 7'd127, 32'd1);
        send_request(FN_INSERT, 7'd7, 32'd1);
        // removal from the end, the middle and both sides
        send_request(FN_ERASE, 7'd5, 32'd0);
        send_request(FN_ERASE, 7'd0, 32'd0);
        send_request(FN_ERASE, 7'd2, 32'd0);
        send_request(FN_POP_BACK, 7'd0, 32'd0);
        send_request(FN_POP_FRONT, 7'd0, 32'd0);
        send_request(FN_FIND, 7'd0, 32'h7FFF_FFFF);

        // random: mostly growing, then mostly shrinking, then mixed
        for (k = 0; k < 400; k++)
        begin
            if (k % 40 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            if (k < 120)
                random_request(85);
            else if (k < 240)
                random_request(15);
            else
                random_request(50);
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;

        // drain, then a short quiet spell for stray responses
        while (board.awaited.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("checked %0d responses, list reached %0d entries, %0d finds hit",
                 board.checked, board.peak_count, board.finds_hit);
        $display("refusals: %0d full, %0d empty, %0d bad position",
                 board.refused_full, board.refused_empty, board.refused_range);
        if (board.mismatches == 0 && board.awaited.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/sle_pkg.sv
rtl/sle_req_if.sv
rtl/sle_rsp_if.sv
rtl/sle_cell.sv
rtl/sle_scan.sv
rtl/sequential_list_engine.sv
sim/sequential_list_engine_test.sv
